FILE: hdl/assert_macros.svh
// Assertion macros shared by the k-mer counter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define KFC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define KFC_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
	else $error(msg);

`endif

FILE: hdl/kfc_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and controller/datapath structs of the k-mer counter.
package kfc_pkg;

	localparam int KMER_LENGTH_DEF = 5;
	localparam int TABLE_DEPTH_DEF = 1024;

	localparam int SYMBOL_W    = 8;
	localparam int READ_IDX_W  = 10;
	localparam int KEY_OUT_W   = 40;
	localparam int COUNT_W     = 32;
	localparam int ENTRY_IDX_W = 10;

	localparam logic OP_FEED    = 1'b0;
	localparam logic OP_READ    = 1'b1;
	localparam logic KIND_COUNT = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	typedef enum logic [1:0] {
		RES_HIT,
		RES_NEW,
		RES_DROP,
		RES_READ
	} res_sel_t;

	typedef struct packed {
		logic     take;
		logic     scan;
		logic     rd_issue;
		logic     hit_write;
		logic     append;
		logic     load;
		res_sel_t sel;
	} kfc_cmd_t;

	typedef struct packed {
		logic accepted;
		logic is_read;
		logic kmer_done;
		logic table_empty;
		logic table_full;
		logic hit;
		logic miss_end;
		logic out_free;
	} kfc_stat_t;

endpackage

FILE: hdl/kfc_item_if.sv
`timescale 1ns / 1ps
// Input item channel of the k-mer counter.
interface kfc_item_if import kfc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  op;
	logic [SYMBOL_W-1:0]   symbol;
	logic                  seq_start;
	logic [READ_IDX_W-1:0] read_index;

	modport source (output valid, op, symbol, seq_start, read_index, input ready);
	modport sink (input valid, op, symbol, seq_start, read_index, output ready);
endinterface

FILE: hdl/kfc_result_if.sv
`timescale 1ns / 1ps
// Result item channel of the k-mer counter.
interface kfc_result_if import kfc_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic                   kind;
	logic [KEY_OUT_W-1:0]   kmer_key;
	logic [COUNT_W-1:0]     count;
	logic [ENTRY_IDX_W-1:0] entry_index;
	logic                   is_new;
	logic                   dropped;
	logic                   entry_valid;

	modport source (output valid, kind, kmer_key, count, entry_index, is_new, dropped,
		entry_valid, input ready);
	modport sink (input valid, kind, kmer_key, count, entry_index, is_new, dropped,
		entry_valid, output ready);
endinterface

FILE: hdl/kfc_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module kfc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hdl/kfc_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the k-mer counter.
module kfc_ctrl import kfc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  kfc_stat_t st,
	output kfc_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD_ISSUE,
		S_SEARCH,
		S_WRITE,
		S_APPEND,
		S_RESULT
	} state_t;

	state_t   state_q;
	res_sel_t sel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sel_q   <= RES_READ;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (st.accepted) begin
						if (st.is_read) begin
							sel_q   <= RES_READ;
							state_q <= S_RD_ISSUE;
						end else if (st.kmer_done) begin
							// An empty table cannot hit, so go straight to insertion.
							state_q <= st.table_empty ? S_APPEND : S_SEARCH;
						end
					end
				end
				S_RD_ISSUE: begin
					state_q <= S_RESULT;
				end
				S_SEARCH: begin
					if (st.hit) begin
						sel_q   <= RES_HIT;
						state_q <= S_WRITE;
					end else if (st.miss_end) begin
						state_q <= S_APPEND;
					end
				end
				S_WRITE: begin
					state_q <= S_RESULT;
				end
				S_APPEND: begin
					sel_q   <= st.table_full ? RES_DROP : RES_NEW;
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (st.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cmd.take      = (state_q == S_IDLE);
		cmd.scan      = (state_q == S_SEARCH);
		cmd.rd_issue  = (state_q == S_RD_ISSUE);
		cmd.hit_write = (state_q == S_WRITE);
		cmd.append    = (state_q == S_APPEND) && !st.table_full;
		cmd.load      = (state_q == S_RESULT) && st.out_free;
		cmd.sel       = sel_q;
	end

endmodule

FILE: hdl/kfc_dp.sv
`timescale 1ns / 1ps
// Datapath of the k-mer counter: window, table memory, search pipeline, result register.
module kfc_dp import kfc_pkg::*; #(
	parameter int KMER_LENGTH = KMER_LENGTH_DEF,
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	kfc_item_if.sink     item,
	kfc_result_if.source result,
	input  kfc_cmd_t  cmd,
	output kfc_stat_t st
);

	localparam int KEY_W   = SYMBOL_W * KMER_LENGTH;
	localparam int ENTRY_W = KEY_W + COUNT_W;
	localparam int IDX_W   = $clog2(TABLE_DEPTH);
	localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
	localparam int FILL_W  = $clog2(KMER_LENGTH + 1);
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(KMER_LENGTH);
	localparam logic [CNT_W-1:0]  USED_MAX  = CNT_W'(TABLE_DEPTH);

	logic [KEY_W-1:0]      window_q, window_base, window_nxt, key_q;
	logic [FILL_W-1:0]     fill_q, fill_base, fill_nxt;
	logic [CNT_W-1:0]      used_q, last_idx;
	logic [IDX_W-1:0]      scan_idx_q, cmp_idx_s1, res_idx_q;
	logic [READ_IDX_W-1:0] rd_index_q;
	logic                  rd_valid_q, issued_all_q, cmp_vld_s1, out_vld_q;
	logic [COUNT_W-1:0]    res_cnt_q, rd_count, count_inc;
	logic [KEY_W-1:0]      rd_key;
	logic                  accept, feed, scan_go, key_eq, hit;

	logic                  ram_we, ram_re;
	logic [IDX_W-1:0]      ram_waddr, ram_raddr;
	logic [ENTRY_W-1:0]    ram_wdata, ram_rdata;

	logic                   res_kind_q, res_new_q, res_drop_q, res_valid_q;
	logic [KEY_OUT_W-1:0]   res_key_q;
	logic [COUNT_W-1:0]     res_count_q;
	logic [ENTRY_IDX_W-1:0] res_entry_q;

	assign item.ready = cmd.take;
	assign accept     = item.valid && cmd.take;
	assign feed       = accept && (item.op == OP_FEED);

	// A start flag empties the window before the new symbol shifts in.
	assign window_base = item.seq_start ? {KEY_W{1'b0}} : window_q;
	assign window_nxt  = KEY_W'({window_base, item.symbol});
	assign fill_base   = item.seq_start ? {FILL_W{1'b0}} : fill_q;
	assign fill_nxt    = (fill_base == FILL_FULL) ? FILL_FULL : fill_base + 1'b1;

	assign last_idx  = used_q - 1'b1;
	assign scan_go   = cmd.scan && !issued_all_q;
	assign rd_key    = ram_rdata[ENTRY_W-1:COUNT_W];
	assign rd_count  = ram_rdata[COUNT_W-1:0];
	assign key_eq    = (rd_key == key_q);
	assign hit       = cmp_vld_s1 && key_eq;
	assign count_inc = (rd_count == {COUNT_W{1'b1}}) ? rd_count : rd_count + 1'b1;

	always_comb begin
		st.accepted    = accept;
		st.is_read     = (item.op == OP_READ);
		st.kmer_done   = (fill_nxt == FILL_FULL);
		st.table_empty = (used_q == '0);
		st.table_full  = (used_q == USED_MAX);
		st.hit         = hit;
		st.miss_end    = cmp_vld_s1 && !key_eq && (CNT_W'(cmp_idx_s1) == last_idx);
		st.out_free    = !out_vld_q || result.ready;
	end

	assign ram_re    = scan_go || cmd.rd_issue;
	assign ram_raddr = cmd.rd_issue ? IDX_W'(rd_index_q) : scan_idx_q;
	assign ram_we    = cmd.hit_write || cmd.append;
	assign ram_waddr = cmd.hit_write ? res_idx_q : IDX_W'(used_q);
	assign ram_wdata = {key_q, (cmd.hit_write ? res_cnt_q : COUNT_W'(1))};

	kfc_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q     <= '0;
			fill_q       <= '0;
			used_q       <= '0;
			issued_all_q <= 1'b0;
			cmp_vld_s1   <= 1'b0;
			out_vld_q    <= 1'b0;
		end else begin
			if (feed) begin
				window_q <= window_nxt;
				fill_q   <= fill_nxt;
			end
			if (cmd.append) begin
				used_q <= used_q + 1'b1;
			end
			cmp_vld_s1 <= scan_go;
			// Reads stop once the last used entry has been issued.
			if (accept) begin
				issued_all_q <= 1'b0;
			end else if (scan_go && (CNT_W'(scan_idx_q) == last_idx)) begin
				issued_all_q <= 1'b1;
			end
			if (cmd.load) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= scan_idx_q;
		if (accept) begin
			key_q      <= window_nxt;
			rd_index_q <= item.read_index;
			rd_valid_q <= (32'(item.read_index) < 32'(used_q));
			scan_idx_q <= '0;
		end else if (scan_go) begin
			scan_idx_q <= scan_idx_q + 1'b1;
		end
		if (cmd.scan && hit) begin
			res_idx_q <= cmp_idx_s1;
			res_cnt_q <= count_inc;
		end else if (cmd.append) begin
			res_idx_q <= IDX_W'(used_q);
			res_cnt_q <= COUNT_W'(1);
		end
		if (cmd.load) begin
			res_kind_q  <= KIND_COUNT;
			res_key_q   <= KEY_OUT_W'(key_q);
			res_count_q <= res_cnt_q;
			res_entry_q <= ENTRY_IDX_W'(res_idx_q);
			res_new_q   <= 1'b0;
			res_drop_q  <= 1'b0;
			res_valid_q <= 1'b0;
			unique case (cmd.sel)
				RES_HIT: begin
				end
				RES_NEW: begin
					res_new_q <= 1'b1;
				end
				RES_DROP: begin
					res_count_q <= '0;
					res_entry_q <= '0;
					res_drop_q  <= 1'b1;
				end
				RES_READ: begin
					res_kind_q  <= KIND_READ;
					res_key_q   <= rd_valid_q ? KEY_OUT_W'(rd_key) : '0;
					res_count_q <= rd_valid_q ? rd_count : '0;
					res_entry_q <= rd_index_q;
					res_valid_q <= rd_valid_q;
				end
				default: begin
				end
			endcase
		end
	end

	assign result.valid       = out_vld_q;
	assign result.kind        = res_kind_q;
	assign result.kmer_key    = res_key_q;
	assign result.count       = res_count_q;
	assign result.entry_index = res_entry_q;
	assign result.is_new      = res_new_q;
	assign result.dropped     = res_drop_q;
	assign result.entry_valid = res_valid_q;

endmodule

FILE: hdl/kmer_frequency_counter_unit.sv
`timescale 1ns / 1ps
// Top level of the k-mer counter: controller, datapath and checks.
// The unit takes one item at a time. A fed symbol that does not complete a
// k-mer leaves the unit idle and ready. A table read passes through accept,
// memory read and result load. A completed k-mer is looked up by a linear scan
// of the table memory through its single read port, one stored entry per
// cycle. A miss scans all used entries (none on an empty table); a hit on
// entry p ends the scan and writes the count back. The result waits in an
// output register, and the next item is taken as soon as the result is loaded
// there; while an earlier result is still waiting, the unit holds in its load
// cycle.
`include "assert_macros.svh"

module kmer_frequency_counter_unit import kfc_pkg::*; #(
	parameter int KMER_LENGTH = KMER_LENGTH_DEF,
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	kfc_item_if.sink     item,
	kfc_result_if.source result
);

	kfc_cmd_t  cmd;
	kfc_stat_t st;

	kfc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.cmd    (cmd)
	);

	kfc_dp #(
		.KMER_LENGTH(KMER_LENGTH),
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.result (result),
		.cmd    (cmd),
		.st     (st)
	);

	`KFC_NEVER(a_load_overwrite, cmd.load && !st.out_free, "result loaded over a pending one")
	`KFC_ASSERT(a_append_room, cmd.append |-> !st.table_full, "append into a full table")
	`KFC_NEVER(a_take_busy, cmd.take && (cmd.scan || cmd.hit_write || cmd.append), "taken busy")
	`KFC_ASSERT(a_hit_write, (cmd.scan && st.hit) |=> cmd.hit_write, "hit without count write-back")

endmodule
